// File: src/lbqm_pkg.sv
// Package for the linked buffer queue manager.
// Holds the command codes, field widths and default sizes; no dependencies.
package lbqm_pkg;

  localparam int DefNumBuffers = 256;
  localparam int DefNumQueues  = 32;

  localparam int KindW  = 3;
  localparam int QueueW = 5;
  localparam int IndexW = 8;
  localparam int CountW = 9;

  localparam int CntMax = 511;

  typedef enum logic [KindW-1:0] {
    KIND_TAKE       = 3'd0,
    KIND_GIVE       = 3'd1,
    KIND_ENQUEUE    = 3'd2,
    KIND_DEQ_SWAP   = 3'd3,
    KIND_DEQ_MAIN   = 3'd4,
    KIND_SHIFT      = 3'd5,
    KIND_FLUSH_ALL  = 3'd6,
    KIND_FLUSH_KEEP = 3'd7
  } kind_e;

endpackage

// File: src/lbqm_if.sv
// Handshake interfaces for the command and response channels.
// Depends on lbqm_pkg for the field widths.
interface lbqm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lbqm_pkg::KindW-1:0]    kind;
  logic [lbqm_pkg::QueueW-1:0]   queue_id;
  logic [lbqm_pkg::IndexW-1:0]   buffer_index;
  logic                          buffer_present;

  modport source (output valid, kind, queue_id, buffer_index, buffer_present, input ready);
  modport sink (input valid, kind, queue_id, buffer_index, buffer_present, output ready);
endinterface

interface lbqm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lbqm_pkg::IndexW-1:0]   result_index;
  logic                          result_present;
  logic [lbqm_pkg::CountW-1:0]   free_left;
  logic [lbqm_pkg::CountW-1:0]   queue_depth;

  modport source (output valid, result_index, result_present, free_left, queue_depth,
                  input ready);
  modport sink (input valid, result_index, result_present, free_left, queue_depth,
                output ready);
endinterface

// File: src/linked_buffer_queue_manager.sv
// Top level of the linked buffer queue manager: free list and linked queues.
// Depends on lbqm_pkg and the channel interfaces in lbqm_if.
//
// One command is taken at a time and yields one response transaction. Each link
// memory read is followed by a write to the same entry in the following cycle;
// other link updates are writes only. After reset the block builds the free
// chain and clears the queue table before it accepts the first command.
module linked_buffer_queue_manager #(
  parameter int NUM_BUFFERS = lbqm_pkg::DefNumBuffers,
  parameter int NUM_QUEUES  = lbqm_pkg::DefNumQueues
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbqm_cmd_if.sink      cmd_i,
  lbqm_rsp_if.source    rsp_o
);

  localparam int LW   = $clog2(NUM_BUFFERS + 1);
  localparam int AW   = $clog2(NUM_BUFFERS);
  localparam int QAW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW   = $clog2(((NUM_BUFFERS > 511) ? NUM_BUFFERS : 511) + 1);
  localparam int DW   = $clog2(NUM_BUFFERS + 2);
  localparam int MAXN = (NUM_BUFFERS > NUM_QUEUES) ? NUM_BUFFERS : NUM_QUEUES;
  localparam int IW   = $clog2(MAXN + 1);
  localparam int TW   = lbqm_pkg::CountW;
  localparam int QRW  = 3 * LW + TW;
  localparam int XW   = lbqm_pkg::IndexW;
  localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_LOADQ, ST_TAKE_W, ST_ENQ2, ST_POP_W, ST_POST,
    ST_DRAIN_R, ST_DRAIN_W, ST_WB, ST_DONE
  } state_e;

  function automatic logic valid_buf(input logic [LW-1:0] b);
    return b < NIL;
  endfunction

  function automatic logic [TW-1:0] inc_q(input logic [TW-1:0] v);
    return (v == TW'(lbqm_pkg::CntMax)) ? v : v + TW'(1);
  endfunction

  function automatic logic [TW-1:0] dec_q(input logic [TW-1:0] v);
    return (v == '0) ? v : v - TW'(1);
  endfunction

  function automatic logic [CW-1:0] inc_f(input logic [CW-1:0] v);
    return (v >= CW'(lbqm_pkg::CntMax)) ? CW'(lbqm_pkg::CntMax) : v + CW'(1);
  endfunction

  function automatic logic [CW-1:0] dec_f(input logic [CW-1:0] v);
    return (v == '0) ? v : v - CW'(1);
  endfunction

  state_e                state_q, state_d;
  lbqm_pkg::kind_e       kind_q, kind_d;
  logic                  qok_q, qok_d;
  logic [QAW-1:0]        qaddr_q, qaddr_d;
  logic [LW-1:0]         buf_q, buf_d;
  logic                  bok_q, bok_d;
  logic [LW-1:0]         head_q, head_d, tail_q, tail_d, last_q, last_d;
  logic [TW-1:0]         tot_q, tot_d;
  logic [LW-1:0]         res_q, res_d, pop_q, pop_d;
  logic [LW-1:0]         free_head_q, free_head_d;
  logic [CW-1:0]         free_tot_q, free_tot_d;
  logic [DW-1:0]         drain_cnt_q, drain_cnt_d;
  logic [IW-1:0]         init_cnt_q, init_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [XW-1:0]         out_idx_q, out_idx_d;
  logic                  out_pres_q, out_pres_d;
  logic [TW-1:0]         out_free_q, out_free_d;
  logic [TW-1:0]         out_depth_q, out_depth_d;

  logic [LW-1:0]  link_mem [NUM_BUFFERS];
  logic           l_we;
  logic [AW-1:0]  l_waddr, l_raddr;
  logic [LW-1:0]  l_wdata, l_rdata_q;

  logic [QRW-1:0] q_mem [NUM_QUEUES];
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [QRW-1:0] q_wdata, q_rdata_q;

  logic [LW-1:0]       rd_head, rd_tail, rd_last;
  logic [TW-1:0]       rd_tot;
  logic [QAW+4:0]      q_ext;
  logic [LW+7:0]       b_ext, res_ext;

  assign rd_head = q_rdata_q[LW-1:0];
  assign rd_tail = q_rdata_q[2*LW-1:LW];
  assign rd_tot  = q_rdata_q[2*LW+TW-1:2*LW];
  assign rd_last = q_rdata_q[QRW-1:2*LW+TW];

  assign q_ext   = {{QAW{1'b0}}, cmd_i.queue_id};
  assign b_ext   = {{LW{1'b0}}, cmd_i.buffer_index};
  assign res_ext = {8'b0, res_q};

  assign cmd_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_index   = out_idx_q;
  assign rsp_o.result_present = out_pres_q;
  assign rsp_o.free_left      = out_free_q;
  assign rsp_o.queue_depth    = out_depth_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    qok_d       = qok_q;
    qaddr_d     = qaddr_q;
    buf_d       = buf_q;
    bok_d       = bok_q;
    head_d      = head_q;
    tail_d      = tail_q;
    last_d      = last_q;
    tot_d       = tot_q;
    res_d       = res_q;
    pop_d       = pop_q;
    free_head_d = free_head_q;
    free_tot_d  = free_tot_q;
    drain_cnt_d = drain_cnt_q;
    init_cnt_d  = init_cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_idx_d   = out_idx_q;
    out_pres_d  = out_pres_q;
    out_free_d  = out_free_q;
    out_depth_d = out_depth_q;
    l_we        = 1'b0;
    l_waddr     = '0;
    l_wdata     = NIL;
    l_raddr     = '0;
    q_we        = 1'b0;
    q_waddr     = qaddr_q;
    q_wdata     = {last_q, tot_q, tail_q, head_q};
    q_raddr     = q_ext[QAW-1:0];

    case (state_q)
      ST_INIT: begin
        l_we    = init_cnt_q < IW'(NUM_BUFFERS);
        l_waddr = init_cnt_q[AW-1:0];
        l_wdata = LW'(init_cnt_q + IW'(1));
        q_we    = init_cnt_q < IW'(NUM_QUEUES);
        q_waddr = init_cnt_q[QAW-1:0];
        q_wdata = {NIL, {TW{1'b0}}, NIL, NIL};
        if (init_cnt_q == IW'(MAXN - 1)) begin
          state_d = ST_IDLE;
        end else begin
          init_cnt_d = init_cnt_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d  = lbqm_pkg::kind_e'(cmd_i.kind);
          qok_d   = q_ext < (QAW+5)'(NUM_QUEUES);
          qaddr_d = q_ext[QAW-1:0];
          buf_d   = b_ext[LW-1:0];
          bok_d   = cmd_i.buffer_present && (b_ext < (LW+8)'(NUM_BUFFERS));
          res_d   = NIL;
          state_d = ST_LOADQ;
        end
      end
      ST_LOADQ: begin
        head_d  = rd_head;
        tail_d  = rd_tail;
        tot_d   = rd_tot;
        last_d  = rd_last;
        state_d = ST_DONE;
        if (kind_q == lbqm_pkg::KIND_TAKE) begin
          if (valid_buf(free_head_q)) begin
            l_raddr = free_head_q[AW-1:0];
            state_d = ST_TAKE_W;
          end
        end else if (kind_q == lbqm_pkg::KIND_GIVE) begin
          if (bok_q) begin
            l_we        = 1'b1;
            l_waddr     = buf_q[AW-1:0];
            l_wdata     = free_head_q;
            free_head_d = buf_q;
            free_tot_d  = inc_f(free_tot_q);
          end
        end else if (qok_q) begin
          case (kind_q)
            lbqm_pkg::KIND_ENQUEUE: begin
              if (bok_q) begin
                l_we    = 1'b1;
                l_waddr = buf_q[AW-1:0];
                l_wdata = NIL;
                tot_d   = inc_q(rd_tot);
                tail_d  = buf_q;
                if (!valid_buf(rd_head) || !valid_buf(rd_tail)) begin
                  head_d  = buf_q;
                  state_d = ST_WB;
                end else begin
                  pop_d   = rd_tail;
                  state_d = ST_ENQ2;
                end
              end
            end
            lbqm_pkg::KIND_FLUSH_ALL: begin
              if (valid_buf(rd_last)) begin
                l_we        = 1'b1;
                l_waddr     = rd_last[AW-1:0];
                l_wdata     = free_head_q;
                free_head_d = rd_last;
                free_tot_d  = inc_f(free_tot_q);
              end
              last_d      = NIL;
              drain_cnt_d = '0;
              state_d     = ST_DRAIN_R;
            end
            lbqm_pkg::KIND_FLUSH_KEEP: begin
              drain_cnt_d = '0;
              state_d     = ST_DRAIN_R;
            end
            default: begin
              if (valid_buf(rd_head)) begin
                l_raddr = rd_head[AW-1:0];
                state_d = ST_POP_W;
              end else begin
                pop_d   = NIL;
                state_d = ST_POST;
              end
            end
          endcase
        end
      end
      ST_TAKE_W: begin
        free_head_d = l_rdata_q;
        l_we        = 1'b1;
        l_waddr     = free_head_q[AW-1:0];
        l_wdata     = NIL;
        free_tot_d  = dec_f(free_tot_q);
        res_d       = free_head_q;
        state_d     = ST_DONE;
      end
      ST_ENQ2: begin
        l_we    = 1'b1;
        l_waddr = pop_q[AW-1:0];
        l_wdata = buf_q;
        state_d = ST_WB;
      end
      ST_POP_W: begin
        pop_d   = head_q;
        head_d  = l_rdata_q;
        if (!valid_buf(l_rdata_q)) begin
          tail_d = NIL;
        end
        l_we    = 1'b1;
        l_waddr = head_q[AW-1:0];
        l_wdata = NIL;
        tot_d   = dec_q(tot_q);
        state_d = ST_POST;
      end
      ST_POST: begin
        case (kind_q)
          lbqm_pkg::KIND_DEQ_SWAP: begin
            res_d  = last_q;
            last_d = pop_q;
          end
          lbqm_pkg::KIND_DEQ_MAIN: begin
            res_d = pop_q;
          end
          default: begin
            if (valid_buf(pop_q)) begin
              res_d  = last_q;
              last_d = pop_q;
            end
          end
        endcase
        state_d = ST_WB;
      end
      ST_DRAIN_R: begin
        if (drain_cnt_q > DW'(NUM_BUFFERS) || !valid_buf(head_q)) begin
          state_d = ST_WB;
        end else begin
          l_raddr = head_q[AW-1:0];
          state_d = ST_DRAIN_W;
        end
      end
      ST_DRAIN_W: begin
        head_d = l_rdata_q;
        if (!valid_buf(l_rdata_q)) begin
          tail_d = NIL;
        end
        tot_d       = dec_q(tot_q);
        l_we        = 1'b1;
        l_waddr     = head_q[AW-1:0];
        l_wdata     = free_head_q;
        free_head_d = head_q;
        free_tot_d  = inc_f(free_tot_q);
        drain_cnt_d = drain_cnt_q + DW'(1);
        state_d     = ST_DRAIN_R;
      end
      ST_WB: begin
        q_we    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_pres_d  = valid_buf(res_q);
          out_idx_d   = valid_buf(res_q) ? res_ext[XW-1:0] : '0;
          out_free_d  = free_tot_q[TW-1:0];
          out_depth_d = qok_q ? tot_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      kind_q      <= lbqm_pkg::KIND_TAKE;
      qok_q       <= 1'b0;
      qaddr_q     <= '0;
      buf_q       <= '0;
      bok_q       <= 1'b0;
      head_q      <= NIL;
      tail_q      <= NIL;
      last_q      <= NIL;
      tot_q       <= '0;
      res_q       <= NIL;
      pop_q       <= NIL;
      free_head_q <= '0;
      free_tot_q  <= CW'(NUM_BUFFERS);
      drain_cnt_q <= '0;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_pres_q  <= 1'b0;
      out_free_q  <= '0;
      out_depth_q <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      qok_q       <= qok_d;
      qaddr_q     <= qaddr_d;
      buf_q       <= buf_d;
      bok_q       <= bok_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      last_q      <= last_d;
      tot_q       <= tot_d;
      res_q       <= res_d;
      pop_q       <= pop_d;
      free_head_q <= free_head_d;
      free_tot_q  <= free_tot_d;
      drain_cnt_q <= drain_cnt_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_pres_q  <= out_pres_d;
      out_free_q  <= out_free_d;
      out_depth_q <= out_depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
    l_rdata_q <= link_mem[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

endmodule

// File: src/lbqm_checker.sv
// Port-level assertions for the linked buffer queue manager, bound to the top.
// Depends on the channel interfaces in lbqm_if.
module lbqm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbqm_cmd_if.sink    cmd_i,
  lbqm_rsp_if.source  rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("Response transaction dropped while stalled.");

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.result_present |-> rsp_o.result_index == '0)
    else $error("Null result carries a nonzero index.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("Command accepted while another is in progress.");

  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && !rsp_o.valid |=> !rsp_o.valid)
    else $error("Response appeared in the cycle after acceptance.");

endmodule

bind linked_buffer_queue_manager lbqm_checker u_lbqm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cmd_i  (cmd_i),
  .rsp_o  (rsp_o)
);
